// File: rtl/atcl_pkg.sv
`timescale 1ns / 1ps

package atcl_pkg;

    localparam int MaxLineDefault = 32;
    localparam int KwCount        = 5;
    localparam int KwTextLen      = 12;
    localparam int ValueW         = 14;
    localparam int PosW           = 4;
    localparam int DigitW         = 3;
    localparam int FieldW         = 2;

    localparam logic [7:0] CharCr    = 8'd13;
    localparam logic [7:0] CharEq    = 8'h3D;
    localparam logic [7:0] CharComma = 8'h2C;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;

    localparam logic [ValueW-1:0] YearMin  = ValueW'(2000);
    localparam logic [ValueW-1:0] YearMax  = ValueW'(2099);
    localparam logic [ValueW-1:0] HourMax  = ValueW'(23);
    localparam logic [ValueW-1:0] MinMax   = ValueW'(59);
    localparam logic [ValueW-1:0] TempMax  = ValueW'(99);
    localparam logic [ValueW-1:0] BeatStep = ValueW'(50);
    localparam int                BeatSteps = 20;

    typedef enum logic [2:0] {
        MSG_TIME      = 3'd0,
        MSG_DATE      = 3'd1,
        MSG_ALARM     = 3'd2,
        MSG_HEARTBEAT = 3'd3,
        MSG_TEMP      = 3'd4
    } msg_t;

    typedef struct packed {
        logic              pre_ok;
        msg_t              msg_type;
        logic [ValueW-1:0] v1;
        logic [ValueW-1:0] v2;
        logic [ValueW-1:0] v3;
    } line_t;

    localparam logic [7:0] KW_TEXT [KwCount][KwTextLen] = '{
        '{"A", "T", "+", "T", "I", "M", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "T", "+", "D", "A", "T", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "T", "+", "A", "L", "A", "R", "M", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "T", "+", "H", "E", "A", "R", "T", "B", "E", "A", "T"},
        '{"A", "T", "+", "T", "E", "M", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [PosW-1:0] KW_LEN [KwCount] = '{
        PosW'(7), PosW'(7), PosW'(8), PosW'(12), PosW'(7)
    };

    localparam logic [FieldW-1:0] KW_FIELDS [KwCount] = '{
        FieldW'(3), FieldW'(3), FieldW'(2), FieldW'(1), FieldW'(2)
    };

    function automatic logic kw_char_match(input int k, input logic [PosW-1:0] pos,
                                           input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < KW_LEN[k])
        begin
            hit = (KW_TEXT[k][pos] == c);
        end
        return hit;
    endfunction

endpackage

// File: rtl/at_command_line_parser.sv
`timescale 1ns / 1ps

// Parses received characters, one per transaction on the slave side, into lines of the
// form KEYWORD=f1[,f2[,f3]] ended by a carriage return, for the keywords AT+TIME, AT+DATE,
// AT+ALARM, AT+HEARTBEAT and AT+TEMP. Every carriage return yields exactly one result
// transaction on the master side; other characters yield none. A result carries an error
// flag, the message type and up to three values, all zero on error. The block takes one
// character per clock cycle unless it is stalled: each character updates the line state
// in the cycle it is accepted, a carriage return moves a snapshot of the line into a check
// register, and the range check then loads the output register from the check register
// once the output register is free. A result is valid on the master side once it has
// passed through the check register and the output register. Input stalls only when both
// the check register and the output register are full and the master side is not ready.

module at_command_line_parser #(
    parameter int MAX_LINE = atcl_pkg::MaxLineDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [13:0] first_value, [27:14] second_value,
                                   // [41:28] third_value, [47:42] zero
    output logic [3:0]  m_tuser    // [0] status, [3:1] message_type
);
    import atcl_pkg::*;

    logic  byte_accept;
    logic  line_end;
    line_t snap;
    logic  values_ok;
    logic  ok;
    logic  out_ready;
    logic  chk_ready;

    logic  chk_valid_reg;
    line_t chk_reg;
    logic  out_valid_reg;
    logic  status_reg;
    msg_t  type_reg;
    logic [ValueW-1:0] v1_reg, v2_reg, v3_reg;

    assign out_ready   = !out_valid_reg || m_tready;
    assign chk_ready   = !chk_valid_reg || out_ready;
    assign s_tready    = chk_ready;
    assign byte_accept = s_tvalid && s_tready;

    atcl_parse #(
        .MAX_LINE (MAX_LINE)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .line_end    (line_end),
        .snap        (snap)
    );

    atcl_range u_range (
        .line      (chk_reg),
        .values_ok (values_ok)
    );

    assign ok = chk_reg.pre_ok && values_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_accept && line_end)
            begin
                chk_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                chk_valid_reg <= 1'b0;
            end

            if (chk_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept && line_end)
        begin
            chk_reg <= snap;
        end
        if (chk_valid_reg && out_ready)
        begin
            status_reg <= !ok;
            type_reg   <= ok ? chk_reg.msg_type : MSG_TIME;
            v1_reg     <= ok ? chk_reg.v1 : '0;
            v2_reg     <= ok ? chk_reg.v2 : '0;
            v3_reg     <= ok ? chk_reg.v3 : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, v3_reg, v2_reg, v1_reg};
    assign m_tuser  = {type_reg, status_reg};

    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && m_tuser[3:1] == 3'd0))
        else $error("error result carries nonzero fields");

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0] && m_tuser[3:1] == MSG_HEARTBEAT)
        |-> (m_tdata[13:0] >= BeatStep && m_tdata[13:0] <= ValueW'(1000)))
        else $error("heartbeat result out of range");

    a_chk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_valid_reg && !out_ready) |=> chk_valid_reg)
        else $error("check stage dropped a line");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (chk_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

// File: rtl/atcl_parse.sv
`timescale 1ns / 1ps

module atcl_parse #(
    parameter int MAX_LINE = atcl_pkg::MaxLineDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_accept,
    input  logic [7:0]          rx_byte,
    output logic                line_end,
    output atcl_pkg::line_t     snap
);
    import atcl_pkg::*;

    localparam int LenW = $clog2(MAX_LINE + 1);

    typedef enum logic {
        PH_HEADER,
        PH_FIELDS
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [KwCount-1:0]  alive_reg, alive_next;
    logic [PosW-1:0]     pos_reg, pos_next;
    logic [FieldW-1:0]   field_reg, field_next;
    logic [DigitW-1:0]   digits_reg, digits_next;
    logic [ValueW-1:0]   v1_reg, v1_next;
    logic [ValueW-1:0]   v2_reg, v2_next;
    logic [ValueW-1:0]   v3_reg, v3_next;
    logic                bad_reg, bad_next;
    logic [LenW-1:0]     len_reg, len_next;

    logic [KwCount-1:0]  hit;
    logic [ValueW-1:0]   digit;
    logic                is_digit;
    msg_t                first_type;
    logic [FieldW-1:0]   want_fields;

    assign line_end = (rx_byte == CharCr);
    assign is_digit = (rx_byte >= CharZero) && (rx_byte <= CharNine);
    assign digit    = ValueW'(rx_byte - CharZero);

    always_comb
    begin
        first_type  = MSG_TIME;
        want_fields = KW_FIELDS[0];
        for (int k = KwCount - 1; k >= 0; k--)
        begin
            if (alive_reg[k])
            begin
                first_type  = msg_t'(k);
                want_fields = KW_FIELDS[k];
            end
        end
    end

    assign snap.pre_ok   = !bad_reg && (phase_reg == PH_FIELDS) && (digits_reg != '0)
                           && (|alive_reg) && (FieldW'(field_reg + 1'b1) == want_fields);
    assign snap.msg_type = first_type;
    assign snap.v1       = v1_reg;
    assign snap.v2       = v2_reg;
    assign snap.v3       = v3_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        alive_next  = alive_reg;
        pos_next    = pos_reg;
        field_next  = field_reg;
        digits_next = digits_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        v3_next     = v3_reg;
        bad_next    = bad_reg;
        len_next    = len_reg;
        hit         = '0;

        if (line_end)
        begin
            phase_next  = PH_HEADER;
            alive_next  = '1;
            pos_next    = '0;
            field_next  = '0;
            digits_next = '0;
            v1_next     = '0;
            v2_next     = '0;
            v3_next     = '0;
            bad_next    = 1'b0;
            len_next    = '0;
        end
        else
        begin
            if (len_reg >= LenW'(MAX_LINE))
            begin
                bad_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + 1'b1;
            end

            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (rx_byte == CharEq)
                    begin
                        for (int k = 0; k < KwCount; k++)
                        begin
                            hit[k] = alive_reg[k] && (KW_LEN[k] == pos_reg);
                        end
                        alive_next = hit;
                        if (hit == '0)
                        begin
                            bad_next = 1'b1;
                        end
                        phase_next = PH_FIELDS;
                    end
                    else
                    begin
                        for (int k = 0; k < KwCount; k++)
                        begin
                            alive_next[k] = alive_reg[k] && kw_char_match(k, pos_reg, rx_byte);
                        end
                        if (pos_reg != '1)
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                PH_FIELDS:
                begin
                    if (is_digit)
                    begin
                        if (digits_reg >= DigitW'(4))
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            case (field_reg)
                                2'd0:    v1_next = (v1_reg << 3) + (v1_reg << 1) + digit;
                                2'd1:    v2_next = (v2_reg << 3) + (v2_reg << 1) + digit;
                                default: v3_next = (v3_reg << 3) + (v3_reg << 1) + digit;
                            endcase
                            digits_next = digits_reg + 1'b1;
                        end
                    end
                    else if (rx_byte == CharComma)
                    begin
                        if ((digits_reg == '0) || (field_reg >= FieldW'(2)))
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            field_next = field_reg + 1'b1;
                        end
                        digits_next = '0;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                default:
                begin
                    bad_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            alive_reg  <= '1;
            pos_reg    <= '0;
            field_reg  <= '0;
            digits_reg <= '0;
            v1_reg     <= '0;
            v2_reg     <= '0;
            v3_reg     <= '0;
            bad_reg    <= 1'b0;
            len_reg    <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg  <= phase_next;
            alive_reg  <= alive_next;
            pos_reg    <= pos_next;
            field_reg  <= field_next;
            digits_reg <= digits_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            v3_reg     <= v3_next;
            bad_reg    <= bad_next;
            len_reg    <= len_next;
        end
    end

endmodule

// File: rtl/atcl_range.sv
`timescale 1ns / 1ps

module atcl_range (
    input  atcl_pkg::line_t line,
    output logic            values_ok
);
    import atcl_pkg::*;

    logic [ValueW-1:0] month_days;
    logic              date_ok;
    logic              beat_ok;

    always_comb
    begin
        case (line.v2)
            ValueW'(4), ValueW'(6), ValueW'(9), ValueW'(11): month_days = ValueW'(30);
            ValueW'(2): month_days = (line.v3[1:0] == 2'b00) ? ValueW'(29) : ValueW'(28);
            default:    month_days = ValueW'(31);
        endcase
    end

    // Within 2000..2099 a year is a leap year exactly when it divides by four.
    assign date_ok = (line.v3 >= YearMin) && (line.v3 <= YearMax)
                     && (line.v2 >= ValueW'(1)) && (line.v2 <= ValueW'(12))
                     && (line.v1 >= ValueW'(1)) && (line.v1 <= month_days);

    always_comb
    begin
        beat_ok = 1'b0;
        for (int k = 1; k <= BeatSteps; k++)
        begin
            if (line.v1 == ValueW'(k * 50))
            begin
                beat_ok = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (line.msg_type)
            MSG_TIME:      values_ok = (line.v1 <= HourMax) && (line.v2 <= MinMax)
                                       && (line.v3 <= MinMax);
            MSG_DATE:      values_ok = date_ok;
            MSG_ALARM:     values_ok = (line.v1 <= HourMax) && (line.v2 <= MinMax);
            MSG_HEARTBEAT: values_ok = beat_ok;
            MSG_TEMP:      values_ok = (line.v1 <= TempMax) && (line.v2 <= TempMax)
                                       && (line.v1 < line.v2);
            default:       values_ok = 1'b0;
        endcase
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import atcl_pkg::*;

    localparam int LineLimit   = 32;
    localparam int TargetBytes = 1400;
    localparam int StallLimit  = 3000;
    localparam int TailCycles  = 10;
    localparam int RowChars    = 40;
    localparam int NumRows     = 30;

    typedef struct packed {
        logic              status;
        msg_t              kind;
        logic [ValueW-1:0] v1;
        logic [ValueW-1:0] v2;
        logic [ValueW-1:0] v3;
    } line_result_t;

    typedef struct packed {
        logic [RowChars*8-1:0] text;
        logic                  pinned;
        line_result_t          want;
    } line_row_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_KEYWORD,
        FLAW_NO_EQUALS,
        FLAW_EXTRA_FIELD,
        FLAW_MISSING_FIELD,
        FLAW_EMPTY_FIELD,
        FLAW_LONG_DIGITS,
        FLAW_STRAY,
        FLAW_LONG_LINE
    } flaw_t;

    localparam line_result_t LineError = '{1'b1, MSG_TIME, 14'd0, 14'd0, 14'd0};

    localparam line_row_t DirectedRows [NumRows] = '{
        '{"", 1'b1, LineError},
        '{"AT+TIME=23,59,59", 1'b1, '{1'b0, MSG_TIME, 14'd23, 14'd59, 14'd59}},
        '{"AT+DATE=29,02,2000", 1'b1, '{1'b0, MSG_DATE, 14'd29, 14'd2, 14'd2000}},
        '{"AT+DATE=29,2,2099", 1'b1, LineError},
        '{"AT+ALARM=0,0", 1'b1, '{1'b0, MSG_ALARM, 14'd0, 14'd0, 14'd0}},
        '{"AT+HEARTBEAT=1000", 1'b1, '{1'b0, MSG_HEARTBEAT, 14'd1000, 14'd0, 14'd0}},
        '{"AT+HEARTBEAT=9999", 1'b1, LineError},
        '{"AT+TEMP=98,99", 1'b1, '{1'b0, MSG_TEMP, 14'd98, 14'd99, 14'd0}},
        '{"AT+TEMP=99,99", 1'b1, LineError},
        '{"at+time=1,2,3", 1'b1, LineError},
        '{"AT+TIME", 1'b1, LineError},
        '{"AT+TIME=1,,3", 1'b1, LineError},
        '{"AT+TIME=12345,0,0", 1'b1, LineError},
        '{"AT+TIME=1,2,3,4", 1'b1, LineError},
        '{"AT+ALARM=1", 1'b1, LineError},
        '{"AT+TIME=1=2,3", 1'b1, LineError},
        '{"AT+TIME=1,2,3x", 1'b1, LineError},
        '{"AT+TIMEX=1,2,3", 1'b1, LineError},
        '{"AT+HEART=50", 1'b1, LineError},
        '{"AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA", 1'b1, LineError},
        '{"AT+DATE=31,4,2024", 1'b1, LineError},
        '{"AT+DATE=1,12,2099", 1'b1, '{1'b0, MSG_DATE, 14'd1, 14'd12, 14'd2099}},
        '{"AT+HEARTBEAT=0050", 1'b1, '{1'b0, MSG_HEARTBEAT, 14'd50, 14'd0, 14'd0}},
        '{"AT+TIME=1,2,", 1'b1, LineError},
        '{"AT+TIME=", 1'b1, LineError},
        '{"AT+HEARTBEAT=75", 1'b1, LineError},
        '{"AT+DATE=29,2,2024", 1'b0, LineError},
        '{"AT+TEMP=0,1", 1'b0, LineError},
        '{"AT+TIME=9,05,0007", 1'b0, LineError},
        '{"AT+ALARM=23,60", 1'b1, LineError}
    };

    string kw_name [KwCount] = '{"AT+TIME", "AT+DATE", "AT+ALARM", "AT+HEARTBEAT", "AT+TEMP"};
    int    kw_field_count [KwCount] = '{3, 3, 2, 1, 2};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;

    // Parser state mirrored from the line rules.
    logic       in_fields;
    logic [4:0] kw_live;
    logic [3:0] hdr_count;
    logic [1:0] field_no;
    logic [2:0] digit_no;
    int         field_val [3];
    logic       line_broken;
    logic [7:0] line_len;

    line_result_t line_results_due [$];
    line_result_t front;
    logic [7:0]   line_buf [$];

    logic quiet = 1'b0;
    int   errors = 0;
    int   bytes_sent = 0;
    int   results_seen = 0;
    int   ok_seen = 0;
    int   random_lines = 0;
    int   noise_lines = 0;
    int   stall_cycles = 0;

    at_command_line_parser #(
        .MAX_LINE(LineLimit)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    task automatic clear_line_state();
        in_fields   = 1'b0;
        kw_live     = 5'h1F;
        hdr_count   = 4'd0;
        field_no    = 2'd0;
        digit_no    = 3'd0;
        field_val   = '{0, 0, 0};
        line_broken = 1'b0;
        line_len    = 8'd0;
    endtask

    function automatic logic fields_in_range(input int k, input int a, input int b, input int c);
        int  days;
        logic leap;
        case (k)
            MSG_TIME:      return a <= 23 && b <= 59 && c <= 59;
            MSG_ALARM:     return a <= 23 && b <= 59;
            MSG_HEARTBEAT: return a >= 50 && a <= 1000 && (a % 50) == 0;
            MSG_TEMP:      return a <= 99 && b <= 99 && a < b;
            MSG_DATE:
            begin
                if (c < 2000 || c > 2099 || b < 1 || b > 12 || a < 1)
                begin
                    return 1'b0;
                end
                leap = ((c % 4) == 0 && (c % 100) != 0) || (c % 400) == 0;
                if (b == 4 || b == 6 || b == 9 || b == 11)
                begin
                    days = 30;
                end
                else if (b == 2)
                begin
                    days = leap ? 29 : 28;
                end
                else
                begin
                    days = 31;
                end
                return a <= days;
            end
            default:       return 1'b0;
        endcase
    endfunction

    task automatic advance_parser(input logic [7:0] c, output logic done,
                                  output line_result_t res);
        int         k;
        int         found;
        logic [4:0] hit;
        done = 1'b0;
        res  = LineError;
        if (c == CharCr)
        begin
            done = 1'b1;
            if (!line_broken && in_fields && digit_no != 3'd0)
            begin
                found = -1;
                for (k = 0; k < KwCount; k++)
                begin
                    if (found < 0 && kw_live[k])
                    begin
                        found = k;
                    end
                end
                if (found >= 0 && int'(field_no) + 1 == kw_field_count[found] &&
                    fields_in_range(found, field_val[0], field_val[1], field_val[2]))
                begin
                    res = '{1'b0, msg_t'(found), ValueW'(field_val[0]),
                            ValueW'(field_val[1]), ValueW'(field_val[2])};
                end
            end
            clear_line_state();
        end
        else
        begin
            if (line_len >= LineLimit)
            begin
                line_broken = 1'b1;
            end
            else
            begin
                line_len++;
            end
            if (!in_fields)
            begin
                if (c == CharEq)
                begin
                    hit = 5'd0;
                    for (k = 0; k < KwCount; k++)
                    begin
                        if (kw_live[k] && kw_name[k].len() == int'(hdr_count))
                        begin
                            hit[k] = 1'b1;
                        end
                    end
                    kw_live = hit;
                    if (hit == 5'd0)
                    begin
                        line_broken = 1'b1;
                    end
                    in_fields = 1'b1;
                end
                else
                begin
                    for (k = 0; k < KwCount; k++)
                    begin
                        if (kw_live[k] && (int'(hdr_count) >= kw_name[k].len() ||
                                           kw_name[k][hdr_count] != c))
                        begin
                            kw_live[k] = 1'b0;
                        end
                    end
                    if (hdr_count < 4'd15)
                    begin
                        hdr_count++;
                    end
                end
            end
            else if (c >= CharZero && c <= CharNine)
            begin
                if (digit_no >= 3'd4)
                begin
                    line_broken = 1'b1;
                end
                else
                begin
                    field_val[field_no] = field_val[field_no] * 10 + int'(c - CharZero);
                    digit_no++;
                end
            end
            else if (c == CharComma)
            begin
                if (digit_no == 3'd0 || field_no >= 2'd2)
                begin
                    line_broken = 1'b1;
                end
                else
                begin
                    field_no++;
                end
                digit_no = 3'd0;
            end
            else
            begin
                line_broken = 1'b1;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic pinned,
                             input line_result_t want);
        logic         done;
        line_result_t res;
        while (!quiet && $urandom_range(99, 0) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        bytes_sent++;
        advance_parser(b, done, res);
        if (done)
        begin
            line_results_due.push_back(pinned ? want : res);
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (line_results_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_buf.push_back(s[i]);
        end
    endtask

    task automatic add_number(input int v);
        string s;
        int    pad;
        s   = $sformatf("%0d", v);
        pad = 0;
        if (s.len() < 4 && $urandom_range(99, 0) < 30)
        begin
            pad = $urandom_range(4 - s.len(), 1);
        end
        repeat (pad) line_buf.push_back(CharZero);
        add_text(s);
    endtask

    function automatic int pick(input int lo, input int hi);
        return ($urandom_range(99, 0) < 85) ? int'($urandom_range(hi, lo))
                                            : int'($urandom_range(9999, 0));
    endfunction

    task automatic build_line();
        string      kw;
        msg_t       k;
        flaw_t      flaw;
        int         count;
        int         v [3];
        logic [7:0] stray;
        line_buf.delete();
        if ($urandom_range(99, 0) < 10)
        begin
            if ($urandom_range(1, 0) == 1)
            begin
                add_text("AT+");
            end
            repeat ($urandom_range(40, 0)) line_buf.push_back(8'($urandom_range(255, 0)));
            noise_lines++;
            return;
        end
        v = '{0, 0, 0};
        k = msg_t'($urandom_range(KwCount - 1, 0));
        case (k)
            MSG_TIME:
            begin
                v[0] = pick(0, 24);
                v[1] = pick(0, 60);
                v[2] = pick(0, 60);
            end
            MSG_DATE:
            begin
                v[1] = ($urandom_range(3, 0) == 0) ? 2 : pick(0, 13);
                v[0] = (v[1] == 2) ? pick(27, 30) : pick(0, 32);
                v[2] = pick(1999, 2100);
            end
            MSG_ALARM:
            begin
                v[0] = pick(0, 24);
                v[1] = pick(0, 60);
            end
            MSG_HEARTBEAT:
            begin
                v[0] = ($urandom_range(1, 0) == 1) ? 50 * int'($urandom_range(21, 0))
                                                   : pick(0, 1050);
            end
            default:
            begin
                v[0] = pick(0, 100);
                v[1] = pick(0, 100);
            end
        endcase
        flaw = ($urandom_range(99, 0) < 72) ? FLAW_NONE
                                           : flaw_t'($urandom_range(FLAW_LONG_LINE, FLAW_KEYWORD));
        kw = kw_name[k];
        if (flaw == FLAW_KEYWORD)
        begin
            kw.putc($urandom_range(kw.len() - 1, 0), 8'($urandom_range(126, 33)));
        end
        add_text(kw);
        if (flaw != FLAW_NO_EQUALS)
        begin
            line_buf.push_back(CharEq);
        end
        count = kw_field_count[k];
        if (flaw == FLAW_EXTRA_FIELD)
        begin
            count++;
        end
        if (flaw == FLAW_MISSING_FIELD)
        begin
            count--;
        end
        for (int i = 0; i < count; i++)
        begin
            if (i > 0)
            begin
                line_buf.push_back(CharComma);
            end
            if (flaw == FLAW_LONG_DIGITS && i == 0)
            begin
                add_text($sformatf("%05d", $urandom_range(99999, 0)));
            end
            else if (!(flaw == FLAW_EMPTY_FIELD && i == count - 1))
            begin
                add_number((i < 3) ? v[i] : int'($urandom_range(9999, 0)));
            end
        end
        if (flaw == FLAW_STRAY)
        begin
            stray = 8'($urandom_range(255, 0));
            if (stray == CharCr || stray == CharComma || (stray >= CharZero && stray <= CharNine))
            begin
                stray = "#";
            end
            line_buf.insert($urandom_range(line_buf.size(), 0), stray);
        end
        if (flaw == FLAW_LONG_LINE)
        begin
            repeat ($urandom_range(40, 12)) line_buf.push_back(" ");
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        m_tready <= quiet || ($urandom_range(99, 0) >= 31);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (line_results_due.size() == 0)
            begin
                report_mismatch("transaction with no line pending", 1, 0);
            end
            else
            begin
                front = line_results_due.pop_front();
                if (m_tuser[0] === 1'b0)
                begin
                    ok_seen++;
                end
                if (m_tuser[0] !== front.status)
                begin
                    report_mismatch("status", m_tuser[0], front.status);
                end
                if (m_tuser[3:1] !== front.kind)
                begin
                    report_mismatch("message_type", m_tuser[3:1], front.kind);
                end
                if (m_tdata[13:0] !== front.v1)
                begin
                    report_mismatch("first_value", m_tdata[13:0], front.v1);
                end
                if (m_tdata[27:14] !== front.v2)
                begin
                    report_mismatch("second_value", m_tdata[27:14], front.v2);
                end
                if (m_tdata[41:28] !== front.v3)
                begin
                    report_mismatch("third_value", m_tdata[41:28], front.v3);
                end
                if (m_tdata[47:42] !== 6'd0)
                begin
                    report_mismatch("tdata padding", m_tdata[47:42], 0);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= StallLimit)
                begin
                    $display("Timeout: no transaction for %0d cycles, %0d lines outstanding",
                             StallLimit, line_results_due.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] ch;
        logic       started;
        clear_line_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NumRows; r++)
        begin
            started = 1'b0;
            for (int i = RowChars - 1; i >= 0; i--)
            begin
                ch = DirectedRows[r].text[i*8 +: 8];
                if (ch != 8'h00)
                begin
                    started = 1'b1;
                end
                if (started)
                begin
                    send_byte(ch, 1'b0, LineError);
                end
            end
            send_byte(CharCr, DirectedRows[r].pinned, DirectedRows[r].want);
        end
        hold_until_drained();

        while (bytes_sent < TargetBytes)
        begin
            quiet = (bytes_sent >= 600 && bytes_sent < 850);
            build_line();
            foreach (line_buf[i])
            begin
                send_byte(line_buf[i], 1'b0, LineError);
            end
            send_byte(CharCr, 1'b0, LineError);
            random_lines++;
            if (random_lines % 40 == 0 && bytes_sent < TargetBytes)
            begin
                hold_until_drained();
            end
        end
        quiet = 1'b0;
        hold_until_drained();
        repeat (TailCycles) @(posedge clk);

        $display("Sent %0d bytes: %0d directed lines, %0d random lines (%0d of them noise).",
                 bytes_sent, NumRows, random_lines, noise_lines);
        $display("Checked %0d result transactions, %0d of them ok, with %0d mismatches.",
                 results_seen, ok_seen, errors);
        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/atcl_pkg.sv
rtl/atcl_parse.sv
rtl/atcl_range.sv
rtl/at_command_line_parser.sv
test/tb_top.sv
